>>> design/bvs_pkg.sv
// Shared types, widths and helpers for the bounded value stepper.
// Used by the front, queue, back end and top level; no dependencies.
package bvs_pkg;

	localparam int VAL_W   = 33;
	localparam int DELTA_W = 8;
	localparam int PROD_W  = 41;
	localparam int SUM_W   = 42;
	localparam int RANGE_W = 34;
	localparam int DIV_W   = 32;
	localparam int NUM_W   = 41;

	typedef enum logic [2:0] {
		TYPE_NONE = 3'd0,
		TYPE_FLAG = 3'd1,
		TYPE_U8   = 3'd2,
		TYPE_U16  = 3'd3,
		TYPE_U32  = 3'd4,
		TYPE_I8   = 3'd5,
		TYPE_I16  = 3'd6,
		TYPE_I32  = 3'd7
	} vtype_t;

	typedef enum logic [1:0] {
		MODE_CLAMP = 2'd0,
		MODE_JUMP  = 2'd1,
		MODE_WRAP  = 2'd2
	} lmode_t;

	typedef enum logic [1:0] {
		CLS_ECHO = 2'd0,
		CLS_BOOL = 2'd1,
		CLS_NUM  = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		KIND_ECHO = 3'd0,
		KIND_BOOL = 3'd1,
		KIND_FIX  = 3'd2,
		KIND_ADD  = 3'd3,
		KIND_SUB  = 3'd4
	} kind_t;

	// One classified request as it waits between front and back end.
	typedef struct packed {
		vtype_t              vtype;
		cls_t                cls;
		lmode_t              mode;
		logic [VAL_W-1:0]    cur;
		logic [VAL_W-1:0]    v;
		logic [VAL_W-1:0]    s;
		logic [DELTA_W-1:0]  d;
		logic [VAL_W-1:0]    lo;
		logic [VAL_W-1:0]    hi;
	} item_t;

	// Front to queue write port.
	typedef struct packed {
		logic  wr;
		item_t item;
	} qwrite_t;

	// Keeps the low bits of x for the type's width, then sign- or zero-extends.
	function automatic logic [VAL_W-1:0] fit_to_type(vtype_t t, logic [DIV_W-1:0] x);
		logic [VAL_W-1:0] r;
		case (t)
			TYPE_FLAG: r = {{(VAL_W-1){1'b0}}, x[0]};
			TYPE_U8:   r = {{(VAL_W-8){1'b0}}, x[7:0]};
			TYPE_U16:  r = {{(VAL_W-16){1'b0}}, x[15:0]};
			TYPE_U32:  r = {1'b0, x};
			TYPE_I8:   r = {{(VAL_W-8){x[7]}}, x[7:0]};
			TYPE_I16:  r = {{(VAL_W-16){x[15]}}, x[15:0]};
			TYPE_I32:  r = {x[31], x};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/bvs_front.sv
// Front end: takes requests, cuts the operands to the value type and classifies them.
// Depends on bvs_pkg; writes into bvs_queue.
module bvs_front (
	input  logic                       start,
	input  logic                       full,
	input  logic [2:0]                 value_type,
	input  logic [bvs_pkg::VAL_W-1:0]  current_value,
	input  logic [bvs_pkg::VAL_W-1:0]  step_size,
	input  logic [bvs_pkg::DELTA_W-1:0] delta,
	input  logic [bvs_pkg::VAL_W-1:0]  low_bound,
	input  logic [bvs_pkg::VAL_W-1:0]  high_bound,
	input  logic [1:0]                 limit_mode,
	output bvs_pkg::qwrite_t           qw
);
	import bvs_pkg::*;

	vtype_t t;

	always_comb begin
		t = vtype_t'(value_type);
		qw.wr         = start && !full;
		qw.item.vtype = t;
		qw.item.cur   = current_value;
		qw.item.v     = fit_to_type(t, current_value[DIV_W-1:0]);
		qw.item.s     = fit_to_type(t, step_size[DIV_W-1:0]);
		qw.item.d     = delta;
		qw.item.lo    = fit_to_type(t, low_bound[DIV_W-1:0]);
		qw.item.hi    = fit_to_type(t, high_bound[DIV_W-1:0]);
		case (limit_mode)
			MODE_CLAMP: qw.item.mode = MODE_CLAMP;
			MODE_JUMP:  qw.item.mode = MODE_JUMP;
			default:    qw.item.mode = MODE_WRAP;
		endcase
		case (t)
			TYPE_NONE: qw.item.cls = CLS_ECHO;
			TYPE_FLAG: qw.item.cls = CLS_BOOL;
			default:   qw.item.cls = CLS_NUM;
		endcase
	end

endmodule

>>> design/bvs_queue.sv
// Short FIFO of classified requests between the front and back end.
// Depends on bvs_pkg for the entry type.
module bvs_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bvs_pkg::qwrite_t qw,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output bvs_pkg::item_t   head
);
	import bvs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (qw.wr) begin
			mem_q[wr_ptr_q] <= qw.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qw.wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({qw.wr, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/bvs_back.sv
// Back end: multiply, sum, limit test, pipelined remainder and final truncation.
// Depends on bvs_pkg; drains bvs_queue every cycle it holds a request.
module bvs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  bvs_pkg::item_t            in_item,
	output logic                      done,
	output logic [bvs_pkg::VAL_W-1:0] new_value,
	output logic                      value_changed
);
	import bvs_pkg::*;

	typedef struct packed {
		vtype_t              vtype;
		cls_t                cls;
		lmode_t              mode;
		logic [VAL_W-1:0]    cur;
		logic [VAL_W-1:0]    v;
		logic [VAL_W-1:0]    lo;
		logic [VAL_W-1:0]    hi;
		logic [PROD_W-1:0]   prod;
	} mul_t;

	typedef struct packed {
		vtype_t              vtype;
		cls_t                cls;
		lmode_t              mode;
		logic [VAL_W-1:0]    cur;
		logic [VAL_W-1:0]    lo;
		logic [VAL_W-1:0]    hi;
		logic [SUM_W-1:0]    sum;
		logic [RANGE_W-1:0]  range;
	} add_t;

	typedef struct packed {
		kind_t               kind;
		vtype_t              vtype;
		logic [VAL_W-1:0]    base;
		logic [DIV_W-1:0]    rem;
		logic [NUM_W-1:0]    num;
		logic [DIV_W-1:0]    dvs;
	} div_t;

	logic  v_s1, v_s2;
	mul_t  mul_s1;
	add_t  add_s2;
	logic  div_v_s [NUM_W+1];
	div_t  div_s   [NUM_W+1];
	div_t  cls_d;

	// Stage 1: step times delta.
	always_ff @(posedge clk) begin
		mul_s1.vtype <= in_item.vtype;
		mul_s1.cls   <= in_item.cls;
		mul_s1.mode  <= in_item.mode;
		mul_s1.cur   <= in_item.cur;
		mul_s1.v     <= in_item.v;
		mul_s1.lo    <= in_item.lo;
		mul_s1.hi    <= in_item.hi;
		mul_s1.prod  <= PROD_W'($signed(in_item.s)) * PROD_W'($signed(in_item.d));
	end

	// Stage 2: wide sum and signed range.
	always_ff @(posedge clk) begin
		add_s2.vtype <= mul_s1.vtype;
		add_s2.cls   <= mul_s1.cls;
		add_s2.mode  <= mul_s1.mode;
		add_s2.cur   <= mul_s1.cur;
		add_s2.lo    <= mul_s1.lo;
		add_s2.hi    <= mul_s1.hi;
		add_s2.sum   <= SUM_W'($signed(mul_s1.v)) + SUM_W'($signed(mul_s1.prod));
		add_s2.range <= RANGE_W'($signed(mul_s1.hi)) - RANGE_W'($signed(mul_s1.lo));
	end

	// Stage 3: limit test, choice of result rule and remainder operands.
	always_comb begin
		logic [SUM_W-1:0]   hi_w, lo_w, d_over, d_under;
		logic [RANGE_W-1:0] arange;
		logic               over, under;
		hi_w    = SUM_W'($signed(add_s2.hi));
		lo_w    = SUM_W'($signed(add_s2.lo));
		over    = $signed(add_s2.sum) > $signed(hi_w);
		under   = $signed(add_s2.sum) < $signed(lo_w);
		d_over  = add_s2.sum - hi_w;
		d_under = lo_w - add_s2.sum;
		arange  = add_s2.range[RANGE_W-1] ? (~add_s2.range + 1'b1) : add_s2.range;

		cls_d.vtype = add_s2.vtype;
		cls_d.rem   = '0;
		cls_d.num   = over ? d_over[NUM_W-1:0] : d_under[NUM_W-1:0];
		cls_d.dvs   = arange[DIV_W-1:0];
		cls_d.kind  = KIND_FIX;
		cls_d.base  = add_s2.sum[VAL_W-1:0];

		if (add_s2.cls == CLS_BOOL) begin
			cls_d.kind = KIND_BOOL;
			cls_d.base = {{(VAL_W-1){1'b0}}, (add_s2.cur == '0)};
		end else if (add_s2.cls == CLS_ECHO || add_s2.range == '0) begin
			cls_d.kind = KIND_ECHO;
			cls_d.base = add_s2.cur;
		end else if (over) begin
			case (add_s2.mode)
				MODE_CLAMP: cls_d.base = add_s2.hi;
				MODE_JUMP:  cls_d.base = add_s2.lo;
				default: begin
					cls_d.kind = KIND_ADD;
					cls_d.base = add_s2.lo;
				end
			endcase
		end else if (under) begin
			case (add_s2.mode)
				MODE_CLAMP: cls_d.base = add_s2.lo;
				MODE_JUMP:  cls_d.base = add_s2.hi;
				default: begin
					cls_d.kind = KIND_SUB;
					cls_d.base = add_s2.hi;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= cls_d;
	end

	// Restoring remainder, one numerator bit per stage, most significant first.
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DIV_W:0] part, trial;
		div_t           nxt;
		always_comb begin
			part  = {div_s[k].rem, div_s[k].num[NUM_W-1]};
			trial = part - {1'b0, div_s[k].dvs};
			nxt       = div_s[k];
			nxt.num   = {div_s[k].num[NUM_W-2:0], 1'b0};
			nxt.rem   = trial[DIV_W] ? part[DIV_W-1:0] : trial[DIV_W-1:0];
		end
		always_ff @(posedge clk) begin
			div_s[k+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i <= NUM_W; i++) begin
				div_v_s[i] <= 1'b0;
			end
		end else begin
			v_s1       <= in_valid;
			v_s2       <= v_s1;
			div_v_s[0] <= v_s2;
			for (int i = 0; i < NUM_W; i++) begin
				div_v_s[i+1] <= div_v_s[i];
			end
		end
	end

	// Final stage: apply the remainder and cut to the type width; echo and boolean results pass through.
	logic [VAL_W-1:0] val_d;
	logic             chg_d;
	logic             done_q;
	logic [VAL_W-1:0] new_value_q;
	logic             changed_q;

	always_comb begin
		div_t f;
		f = div_s[NUM_W];
		chg_d = 1'b1;
		case (f.kind)
			KIND_ECHO: begin
				val_d = f.base;
				chg_d = 1'b0;
			end
			KIND_BOOL: val_d = f.base;
			KIND_ADD:  val_d = fit_to_type(f.vtype, f.base[DIV_W-1:0] + f.rem);
			KIND_SUB:  val_d = fit_to_type(f.vtype, f.base[DIV_W-1:0] - f.rem);
			default:   val_d = fit_to_type(f.vtype, f.base[DIV_W-1:0]);
		endcase
	end

	always_ff @(posedge clk) begin
		new_value_q <= val_d;
		changed_q   <= chg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v_s[NUM_W];
		end
	end

	assign done          = done_q;
	assign new_value     = new_value_q;
	assign value_changed = changed_q;

endmodule

>>> design/bounded_value_stepper.sv
// Bounded value stepper: adds step times delta to a typed value and applies
// clamp, jump or modular carry at the limits; a boolean toggles, type none echoes.
//
// Request channel: drive the fields and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy is high only while the
// request queue is full, which the back end drains every cycle.
// Result channel: done is high for exactly one cycle with new_value and
// value_changed; the receiver must take it then, it cannot hold results off.
// Throughput: one request per cycle, back to back.
// After the edge that takes the request, the multiply stage reads it from the
// queue on the next edge; then follow the sum, limit test, 41 stages of the
// bit-per-stage remainder unit, and the output register that drives done. The
// remainder unit has one stage for each bit of the 41-bit overshoot.
// Results leave in request order.
// Reset (arst_n low, asynchronous) empties the queue and drops every request
// in flight; no done strobe follows until new requests are taken.
// Depends on bvs_pkg, bvs_front, bvs_queue and bvs_back.
module bounded_value_stepper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  value_type,
	input  logic [bvs_pkg::VAL_W-1:0]   current_value,
	input  logic [bvs_pkg::VAL_W-1:0]   step_size,
	input  logic [bvs_pkg::DELTA_W-1:0] delta,
	input  logic [bvs_pkg::VAL_W-1:0]   low_bound,
	input  logic [bvs_pkg::VAL_W-1:0]   high_bound,
	input  logic [1:0]                  limit_mode,
	output logic                        done,
	output logic [bvs_pkg::VAL_W-1:0]   new_value,
	output logic                        value_changed
);
	import bvs_pkg::*;

	qwrite_t qw;
	item_t   head;
	logic    full;
	logic    q_valid;

	assign busy = full;

	bvs_front u_front (
		.start         (start),
		.full          (full),
		.value_type    (value_type),
		.current_value (current_value),
		.step_size     (step_size),
		.delta         (delta),
		.low_bound     (low_bound),
		.high_bound    (high_bound),
		.limit_mode    (limit_mode),
		.qw            (qw)
	);

	bvs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qw     (qw),
		.pop    (q_valid),
		.full   (full),
		.valid  (q_valid),
		.head   (head)
	);

	bvs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_item       (head),
		.done          (done),
		.new_value     (new_value),
		.value_changed (value_changed)
	);

endmodule

>>> tb/sv/tb_bounded_value_stepper.sv
// Self-checking testbench for bounded_value_stepper: directed and random requests
// with random idle gaps, each result checked against a local prediction in order.
// Depends on bvs_pkg and the bounded_value_stepper top level.
module tb_bounded_value_stepper;
	import bvs_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct {
		int               seq;
		logic [VAL_W-1:0] value;
		logic             changed;
	} step_result_t;

	// Limit mode three is outside the enum but handled like the modular carry.
	localparam logic [1:0] MODE_WRAP_ALT = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [2:0]          value_type;
	logic [VAL_W-1:0]    current_value;
	logic [VAL_W-1:0]    step_size;
	logic [DELTA_W-1:0]  delta;
	logic [VAL_W-1:0]    low_bound;
	logic [VAL_W-1:0]    high_bound;
	logic [1:0]          limit_mode;
	logic                done;
	logic [VAL_W-1:0]    new_value;
	logic                value_changed;

	step_result_t pending_results[$];
	int           mismatches;
	int           requests_sent;
	int           cycles;
	bit           idle_enabled;

	bounded_value_stepper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value_type    (value_type),
		.current_value (current_value),
		.step_size     (step_size),
		.delta         (delta),
		.low_bound     (low_bound),
		.high_bound    (high_bound),
		.limit_mode    (limit_mode),
		.done          (done),
		.new_value     (new_value),
		.value_changed (value_changed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int type_bits(vtype_t t);
		case (t)
			TYPE_FLAG:          return 1;
			TYPE_U8, TYPE_I8:   return 8;
			TYPE_U16, TYPE_I16: return 16;
			TYPE_U32, TYPE_I32: return 32;
			default:            return 0;
		endcase
	endfunction

	// Low bits of x for the type's width, sign-extended when signed; flag and none give 0.
	function automatic longint type_cut(vtype_t t, logic [63:0] x);
		case (t)
			TYPE_U8:  return longint'(x[7:0]);
			TYPE_U16: return longint'(x[15:0]);
			TYPE_U32: return longint'(x[31:0]);
			TYPE_I8:  return longint'($signed(x[7:0]));
			TYPE_I16: return longint'($signed(x[15:0]));
			TYPE_I32: return longint'($signed(x[31:0]));
			default:  return 0;
		endcase
	endfunction

	function automatic step_result_t predict_step(vtype_t t, logic [VAL_W-1:0] cur,
			logic [VAL_W-1:0] step, logic [DELTA_W-1:0] d, logic [VAL_W-1:0] lo_raw,
			logic [VAL_W-1:0] hi_raw, logic [1:0] mode);
		step_result_t r;
		longint v, s, dl, lo, hi, sum, range, res;
		u64_t arange;
		r.seq = 0;
		r.value = cur;
		r.changed = 1'b0;
		if (t == TYPE_NONE)
			return r;
		if (t == TYPE_FLAG) begin
			r.value = (cur == '0) ? 33'd1 : 33'd0;
			r.changed = 1'b1;
			return r;
		end
		v = type_cut(t, {31'd0, cur});
		s = type_cut(t, {31'd0, step});
		lo = type_cut(t, {31'd0, lo_raw});
		hi = type_cut(t, {31'd0, hi_raw});
		dl = longint'($signed(d));
		sum = v + s * dl;
		range = hi - lo;
		if (range == 0)
			return r;
		arange = (range < 0) ? u64_t'(-range) : u64_t'(range);
		// The upper test comes first, which matters once the limits are inverted.
		if (sum > hi) begin
			case (mode)
				MODE_CLAMP: res = hi;
				MODE_JUMP:  res = lo;
				default:    res = lo + longint'(u64_t'(sum - hi) % arange);
			endcase
		end else if (sum < lo) begin
			case (mode)
				MODE_CLAMP: res = lo;
				MODE_JUMP:  res = hi;
				default:    res = hi - longint'(u64_t'(lo - sum) % arange);
			endcase
		end else begin
			res = sum;
		end
		res = type_cut(t, res);
		r.value = res[VAL_W-1:0];
		r.changed = 1'b1;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] rand_word();
		return {1'($urandom_range(0, 1)), 32'($urandom())};
	endfunction

	// Places val in the low type-width bits; the bits above carry random noise.
	function automatic logic [VAL_W-1:0] to_raw(vtype_t t, longint val);
		logic [VAL_W-1:0] mask;
		mask = (33'd1 << type_bits(t)) - 33'd1;
		return (rand_word() & ~mask) | (val[VAL_W-1:0] & mask);
	endfunction

	function automatic int draw_gap();
		int p;
		if (!idle_enabled)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	// Drives one request, waits until it is taken, then idles for a random gap.
	// Start stays high when no gap follows, so back-to-back requests are possible.
	task automatic send_request(vtype_t t, logic [VAL_W-1:0] cur, logic [VAL_W-1:0] step,
			logic [DELTA_W-1:0] d, logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
			logic [1:0] mode);
		step_result_t predicted;
		int gap;
		predicted = predict_step(t, cur, step, d, lo, hi, mode);
		predicted.seq = requests_sent;
		value_type <= t;
		current_value <= cur;
		step_size <= step;
		delta <= d;
		low_bound <= lo;
		high_bound <= hi;
		limit_mode <= mode;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predicted);
		requests_sent++;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_passthrough_types();
		send_request(TYPE_NONE, 33'h1_FFFF_FFFF, 33'd5, 8'sd1, 33'd0, 33'd10, MODE_CLAMP);
		send_request(TYPE_FLAG, 33'd0, 33'd1, 8'sd1, 33'd0, 33'd1, MODE_CLAMP);
		send_request(TYPE_FLAG, 33'd1, 33'd1, -8'sd1, 33'd0, 33'd1, MODE_JUMP);
		// Only the top bit set still counts as a nonzero boolean.
		send_request(TYPE_FLAG, 33'h1_0000_0000, 33'd0, 8'sd0, 33'd0, 33'd0, MODE_WRAP);
		send_request(TYPE_U8, 33'd20, 33'd3, 8'sd1, 33'd50, 33'h1_0000_0032, MODE_WRAP);
		send_request(TYPE_U16, 33'd1234, 33'd0, 8'sd127, 33'd0, 33'd65535, MODE_CLAMP);
	endtask

	task automatic test_limit_handling();
		send_request(TYPE_U8, 33'd250, 33'd10, 8'sd1, 33'd0, 33'd255, MODE_CLAMP);
		send_request(TYPE_U8, 33'd250, 33'd10, 8'sd1, 33'd0, 33'd200, MODE_JUMP);
		send_request(TYPE_U8, 33'd250, 33'd10, 8'sd1, 33'd7, 33'd200, MODE_WRAP);
		send_request(TYPE_U8, 33'd3, 33'd5, -8'sd1, 33'd2, 33'd200, MODE_CLAMP);
		send_request(TYPE_U8, 33'd3, 33'd5, -8'sd1, 33'd2, 33'd200, MODE_JUMP);
		send_request(TYPE_U8, 33'd3, 33'd5, -8'sd1, 33'd2, 33'd200, MODE_WRAP);
		send_request(TYPE_U8, 33'd3, 33'd5, -8'sd1, 33'd2, 33'd200, MODE_WRAP_ALT);
		send_request(TYPE_I32, 33'h0_7FFF_FFFF, 33'h0_7FFF_FFFF, 8'sd127,
			33'h1_8000_0000, 33'h0_7FFF_FFFF, MODE_WRAP);
		send_request(TYPE_I32, 33'h1_8000_0000, 33'h0_7FFF_FFFF, -8'sd128,
			33'h0_8000_0000, 33'h0_7FFF_FFFF, MODE_CLAMP);
		send_request(TYPE_U32, 33'h0_FFFF_FFFF, 33'h1_FFFF_FFFF, 8'sd127,
			33'd0, 33'h0_FFFF_FFFF, MODE_WRAP);
		send_request(TYPE_U32, 33'd0, 33'h0_FFFF_FFFF, -8'sd128,
			33'd1, 33'h0_FFFF_FFFE, MODE_WRAP_ALT);
		// Inverted limits: upper is below lower.
		send_request(TYPE_I16, 33'd0, 33'd1, 8'sd1, 33'd100, 33'h1_FFFF_FF9C, MODE_WRAP);
		send_request(TYPE_I16, 33'd0, 33'd1, 8'sd1, 33'd100, 33'h1_FFFF_FF9C, MODE_JUMP);
		send_request(TYPE_I8, 33'h1_FFFF_FFFB, 33'd3, 8'sd2, 33'h0_0000_0080,
			33'h0_0000_007F, MODE_CLAMP);
		send_request(TYPE_I8, 33'h1_5555_55FF, 33'h1_AAAA_AA80, 8'sd127,
			33'h1_FFFF_FF80, 33'h1_0000_007F, MODE_WRAP);
		send_request(TYPE_I16, 33'h0_0000_8000, 33'h0_0000_7FFF, -8'sd128,
			33'h0_0000_8000, 33'h0_0000_7FFF, MODE_JUMP);
	endtask

	// Narrow limits with the value near them, so the limit rules fire often.
	task automatic test_random_steps(int count);
		vtype_t t;
		longint lo_val, hi_val, v_val, tmp;
		int span, p;
		logic [VAL_W-1:0] cur, step, lo, hi;
		logic [DELTA_W-1:0] d;
		logic [1:0] mode;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) == 0)
				idle_enabled = !idle_enabled;
			p = $urandom_range(0, 99);
			if (p < 4)
				t = TYPE_NONE;
			else if (p < 9)
				t = TYPE_FLAG;
			else
				t = vtype_t'($urandom_range(TYPE_U8, TYPE_I32));
			lo_val = type_cut(t, {31'd0, rand_word()});
			p = $urandom_range(0, 99);
			span = (p < 4) ? 0 : $urandom_range(1, 300);
			hi_val = lo_val + span;
			v_val = lo_val + $urandom_range(0, span + 20) - 10;
			if (p >= 88)
				hi_val = type_cut(t, {31'd0, rand_word()});
			if ($urandom_range(0, 9) == 0) begin
				tmp = lo_val;
				lo_val = hi_val;
				hi_val = tmp;
			end
			lo = to_raw(t, lo_val);
			hi = to_raw(t, hi_val);
			cur = to_raw(t, v_val);
			if (t == TYPE_FLAG && $urandom_range(0, 1) == 0)
				cur = '0;
			p = $urandom_range(0, 99);
			if (p < 70)
				step = to_raw(t, $urandom_range(0, 40));
			else if (p < 90)
				step = rand_word();
			else
				step = to_raw(t, 1);
			p = $urandom_range(0, 99);
			if (p < 70)
				d = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
			else if (p < 90)
				d = 8'($urandom_range(0, 8) - 4);
			else
				d = 8'($urandom());
			p = $urandom_range(0, 9);
			mode = (p < 3) ? MODE_CLAMP : (p < 6) ? MODE_JUMP : (p < 9) ? MODE_WRAP
				: MODE_WRAP_ALT;
			send_request(t, cur, step, d, lo, hi, mode);
		end
	endtask

	task automatic test_random_noise(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 49) == 0)
				idle_enabled = !idle_enabled;
			send_request(vtype_t'($urandom_range(0, 7)), rand_word(), rand_word(),
				8'($urandom()), rand_word(), rand_word(), 2'($urandom_range(0, 3)));
		end
	endtask

	// Results cannot be held off, so every done strobe is checked on the edge it ends.
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h/%b with no request outstanding",
					new_value, value_changed));
			end else begin
				want = pending_results.pop_front();
				if (new_value !== want.value)
					report_mismatch($sformatf("request %0d: new_value %h, expected %h",
						want.seq, new_value, want.value));
				if (value_changed !== want.changed)
					report_mismatch($sformatf("request %0d: value_changed %b, expected %b",
						want.seq, value_changed, want.changed));
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bounded_value_stepper regression: fail");
		$finish;
	end

	initial begin
		mismatches = 0;
		requests_sent = 0;
		idle_enabled = 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		value_type <= TYPE_NONE;
		current_value <= '0;
		step_size <= '0;
		delta <= '0;
		low_bound <= '0;
		high_bound <= '0;
		limit_mode <= MODE_CLAMP;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_types();
		test_limit_handling();
		test_random_steps(1000);
		test_random_noise(250);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("bounded_value_stepper regression: pass");
		else
			$display("bounded_value_stepper regression: fail");
		$finish;
	end

endmodule
